/* rtl/core/dbma_pkg.sv */
// package for the dihedral block map adjust core
// holds sizing constants, register indexes and the symmetry decode
// no dependencies
package dbma_pkg;

	localparam int SRC_DIM_DEF    = 256;
	localparam int PIXEL_BITS_DEF = 12;
	localparam int COEF_FRAC      = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int POS_W          = 8;
	localparam int DIM_W          = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CROP_LEFT   = 3'd0,
		REG_CROP_TOP    = 3'd1,
		REG_CROP_WIDTH  = 3'd2,
		REG_CROP_HEIGHT = 3'd3,
		REG_OUT_WIDTH   = 3'd4,
		REG_OUT_HEIGHT  = 3'd5,
		REG_CONTRAST    = 3'd6,
		REG_BRIGHTNESS  = 3'd7
	} cfg_reg_t;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// one row of the dihedral table, coefficients in {-1,0,1}
	typedef struct packed {
		logic       swap;   // x and y exchanged
		logic       neg_x;  // destination column mirrored
		logic       neg_y;  // destination row mirrored
	} sym_t;

	function automatic sym_t sym_decode(input logic [2:0] s);
		sym_t r;
		unique case (s)
			3'd0: r = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
			3'd1: r = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
			3'd2: r = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
			3'd3: r = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
			3'd4: r = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
			3'd5: r = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
			3'd6: r = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
			default: r = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/dbma_div.sv */
// pipelined restoring divider, one quotient bit per stage
// computes floor(num / den) for unsigned num of NUM_W and den of DEN_W bits
// depends on nothing but its parameters
module dbma_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	localparam int R_W = DEN_W + 1;

	logic [NUM_W-1:0] num_q [1:NUM_W];
	logic [R_W-1:0]   rem_q [1:NUM_W];
	logic [DEN_W-1:0] den_q [1:NUM_W];

	// one stage per quotient bit, shifting quotient bits in from below
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [NUM_W-1:0] n_in;
		logic [R_W-1:0]   r_in;
		logic [DEN_W-1:0] d_in;
		logic [R_W-1:0]   trial;
		logic [R_W-1:0]   shifted;
		if (i == 0) begin : g_head
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_link
			assign n_in = num_q[i];
			assign r_in = rem_q[i];
			assign d_in = den_q[i];
		end
		always_comb begin
			shifted = {r_in[R_W-2:0], n_in[NUM_W-1]};
			trial   = shifted - {1'b0, d_in};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[i+1] <= d_in;
				if (shifted >= {1'b0, d_in}) begin
					rem_q[i+1] <= trial;
					num_q[i+1] <= {n_in[NUM_W-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= shifted;
					num_q[i+1] <= {n_in[NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = num_q[NUM_W];
endmodule

/* rtl/core/dihedral_block_map_adjust_core.sv */
// dihedral block mapper: source store, crop scaling, gain/offset and symmetry
// pipe: one product stage, two 17-stage column/row dividers, one store read,
// one multiply and one clamp stage
// one item per cycle unless stalled; a load passes the pipe as a bubble and writes the store
// at the read stage, so store reads and writes stay in item order
// the pipe stalls as a whole when its last stage holds a result not taken
// reset clears control and the configuration registers; the source store is not cleared
module dihedral_block_map_adjust_core
	import dbma_pkg::*;
#(
	parameter int SRC_DIM    = SRC_DIM_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// operation, pos_x, pos_y, pixel_in, symmetry (low to high)
	input  logic [31:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// dst_x, dst_y, pixel_out, error (low to high), zero fill
	output logic [31:0]           m_axis_tdata
);
	localparam int AW     = $clog2(SRC_DIM);
	localparam int PROD_W = 2 * DIM_W - 1;       // pos * crop dim, 17 bits
	localparam int DIV_LAT = PROD_W;
	localparam int NSTG   = DIV_LAT + 4;
	localparam int SUM_W  = 16 + PIXEL_BITS + 4;
	localparam logic [SUM_W-1:0] PMAX = SUM_W'((1 << PIXEL_BITS) - 1);
	localparam int RA = DIV_LAT + 1;   // stage where quotients are ready

	// input fields
	logic             in_op;
	logic [POS_W-1:0] in_x, in_y;
	logic [11:0]      in_pix;
	logic [2:0]       in_sym;
	assign in_op  = s_axis_tdata[0];
	assign in_x   = s_axis_tdata[8:1];
	assign in_y   = s_axis_tdata[16:9];
	assign in_pix = s_axis_tdata[28:17];
	assign in_sym = s_axis_tdata[31:29];

	// configuration registers
	logic [POS_W-1:0]  crop_left_q, crop_top_q;
	logic [DIM_W-1:0]  crop_w_q, crop_h_q, out_w_q, out_h_q;
	logic [15:0]       contrast_q, bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_left_q <= '0;
			crop_top_q  <= '0;
			crop_w_q    <= DIM_W'(16);
			crop_h_q    <= DIM_W'(16);
			out_w_q     <= DIM_W'(8);
			out_h_q     <= DIM_W'(8);
			contrast_q  <= 16'd4096;
			bright_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CROP_LEFT:   crop_left_q <= cfg_data[POS_W-1:0];
				REG_CROP_TOP:    crop_top_q  <= cfg_data[POS_W-1:0];
				REG_CROP_WIDTH:  crop_w_q    <= cfg_data[DIM_W-1:0];
				REG_CROP_HEIGHT: crop_h_q    <= cfg_data[DIM_W-1:0];
				REG_OUT_WIDTH:   out_w_q     <= cfg_data[DIM_W-1:0];
				REG_OUT_HEIGHT:  out_h_q     <= cfg_data[DIM_W-1:0];
				REG_CONTRAST:    contrast_q  <= cfg_data;
				default:         bright_q    <= cfg_data;
			endcase
		end
	end

	// pipe advance: everything moves unless the final result is held
	logic adv;
	logic [NSTG-1:0] vld_q;
	logic [RA-1:0]   ld_q;
	assign adv = !vld_q[NSTG-1] || m_axis_tready;
	assign s_axis_tready = adv;

	logic take;
	assign take = s_axis_tvalid && s_axis_tready;

	// load that lands inside the store
	logic ld_in;
	assign ld_in = take && in_op == OP_LOAD && 32'(in_x) < SRC_DIM && 32'(in_y) < SRC_DIM;

	// bad compute check at entry
	logic [DIM_W:0] sum_l, sum_t;
	logic bad_in;
	assign sum_l = {1'b0, DIM_W'(crop_left_q)} + {1'b0, crop_w_q};
	assign sum_t = {1'b0, DIM_W'(crop_top_q)} + {1'b0, crop_h_q};
	assign bad_in = out_w_q == '0 || out_h_q == '0 ||
		DIM_W'(in_x) >= out_w_q || DIM_W'(in_y) >= out_h_q ||
		crop_w_q == '0 || crop_h_q == '0 ||
		32'(sum_l) > 32'(SRC_DIM) || 32'(sum_t) > 32'(SRC_DIM);

	// destination coordinate from the symmetry decode
	sym_t sd;
	logic [POS_W-1:0] ax, ay, rw, rh, dx_in, dy_in;
	assign sd = sym_decode(in_sym);
	assign ax = sd.swap ? in_y : in_x;
	assign ay = sd.swap ? in_x : in_y;
	assign rw = sd.swap ? out_h_q[POS_W-1:0] - 1'b1 : out_w_q[POS_W-1:0] - 1'b1;
	assign rh = sd.swap ? out_w_q[POS_W-1:0] - 1'b1 : out_h_q[POS_W-1:0] - 1'b1;
	assign dx_in = sd.neg_x ? rw - ax : ax;
	assign dy_in = sd.neg_y ? rh - ay : ay;

	// stage 1: products for the dividers
	logic [PROD_W-1:0] px_s1, py_s1;
	logic [DIM_W-1:0]  dw_s1, dh_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= PROD_W'(in_x * crop_w_q);
			py_s1 <= PROD_W'(in_y * crop_h_q);
			dw_s1 <= out_w_q;
			dh_s1 <= out_h_q;
		end
	end

	logic [PROD_W-1:0] qx, qy;
	dbma_div #(.NUM_W(PROD_W), .DEN_W(DIM_W)) u_div_x (
		.clk(clk), .en(adv), .num(px_s1), .den(dw_s1), .quo(qx));
	dbma_div #(.NUM_W(PROD_W), .DEN_W(DIM_W)) u_div_y (
		.clk(clk), .en(adv), .num(py_s1), .den(dh_s1), .quo(qy));

	// side band that travels with the item
	typedef struct packed {
		logic                  bad;
		logic [POS_W-1:0]      dx;
		logic [POS_W-1:0]      dy;
		logic [2*AW-1:0]       waddr;
		logic [PIXEL_BITS-1:0] wpix;
	} side_t;
	side_t side_q [NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ld_q  <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], take && in_op == OP_COMPUTE};
			ld_q  <= {ld_q[RA-2:0], ld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{bad: bad_in, dx: dx_in, dy: dy_in,
				waddr: {AW'(in_y), AW'(in_x)}, wpix: PIXEL_BITS'(in_pix)};
			for (int i = 1; i < NSTG; i++) side_q[i] <= side_q[i-1];
		end
	end

	// source store, written by loads and read by computes at the same stage
	logic [PIXEL_BITS-1:0] store_mem [SRC_DIM*SRC_DIM];
	logic [PIXEL_BITS-1:0] rd_q;
	logic [2*AW-1:0] rd_addr;
	assign rd_addr = {AW'(qy) + AW'(crop_top_q), AW'(qx) + AW'(crop_left_q)};

	always_ff @(posedge clk) begin
		if (adv && ld_q[RA-1])
			store_mem[side_q[RA-1].waddr] <= side_q[RA-1].wpix;
		if (adv)
			rd_q <= store_mem[rd_addr];
	end

	// multiply stage, floor shift and offset, then clamp
	logic signed [SUM_W-1:0] prod_s3;
	logic signed [SUM_W-1:0] boff;
	generate
		if (PIXEL_BITS >= COEF_FRAC) begin : g_bl
			assign boff = SUM_W'(signed'(bright_q)) <<< (PIXEL_BITS - COEF_FRAC);
		end else begin : g_br
			assign boff = SUM_W'(signed'(bright_q)) >>> (COEF_FRAC - PIXEL_BITS);
		end
	endgenerate

	logic [PIXEL_BITS-1:0] pix_s4;
	logic signed [SUM_W-1:0] val;
	assign val = (prod_s3 >>> COEF_FRAC) + boff;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= SUM_W'(signed'(contrast_q) * signed'({1'b0, rd_q}));
			if (val < 0)
				pix_s4 <= '0;
			else if (val > signed'(PMAX))
				pix_s4 <= PIXEL_BITS'(PMAX);
			else
				pix_s4 <= PIXEL_BITS'(val);
		end
	end

	// result
	side_t so;
	logic [11:0] pout;
	assign so   = side_q[NSTG-1];
	assign pout = so.bad ? 12'd0 : 12'(pix_s4);
	assign m_axis_tvalid = vld_q[NSTG-1];
	assign m_axis_tdata  = {3'd0, so.bad, pout,
		so.bad ? 8'd0 : so.dy, so.bad ? 8'd0 : so.dx};
	// stage RA is where the store is addressed
	if (RA + 3 != NSTG) begin : g_chk
		$error("pipe depth mismatch");
	end
endmodule

/* rtl/core/dbma_checker.sv */
// port-level checks for the dihedral block map adjust core
// depends on nothing and binds to the top level
module dbma_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	// a held result keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// an errored result carries zero coordinates and pixel
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tdata[27:0] == 28'd0)
		else $error("error result not zeroed");
	// input is refused only while a result is held
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("ready dropped without back pressure");
	// nothing comes out right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("result out of reset");
endmodule

bind dihedral_block_map_adjust_core dbma_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
